@@ hw/rtl/gmfw_pkg.sv @@
`timescale 1ns / 1ps

package gmfw_pkg;

	// Fixed field widths
	localparam int PIX_W     = 8;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int COL_W     = 13;
	localparam int ROW_W     = 13;
	localparam int Q_W       = 26;	// linear stream position, pixels plus drain
	localparam int N_W       = 25;	// outputs given in this frame

	// Defaults and limits
	localparam int DEF_WINDOW    = 5;
	localparam int DEF_MAX_WIDTH = 4096;
	localparam int MAX_HEIGHT    = 4096;
	localparam int RST_WIDTH     = 640;
	localparam int RST_HEIGHT    = 480;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic             flush;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] max_value;
		logic             frame_end;
	} pix_out_t;

	// One step of the stream position, handed down the pipeline
	typedef struct packed {
		logic             emit;
		logic             frame_end;
		logic [PIX_W-1:0] pixel;
		logic [COL_W-1:0] col;
	} step_t;

	typedef struct packed {
		logic catch_up;
		logic cfg_pend;
	} ctrl_stat_t;

	function automatic logic [PIX_W-1:0] pix_max(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

@@ hw/rtl/gmfw_ctrl.sv @@
`timescale 1ns / 1ps

module gmfw_ctrl #(
	parameter int WINDOW    = gmfw_pkg::DEF_WINDOW,
	parameter int MAX_WIDTH = gmfw_pkg::DEF_MAX_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr,
	input  logic [gmfw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gmfw_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  gmfw_pkg::pix_in_t                in_data,
	input  logic                             s1_free,
	output logic                             issue,
	output gmfw_pkg::step_t                  step,
	output logic [2*((WINDOW-1)/2):0]        row_mask,
	output logic [2*((WINDOW-1)/2):0]        col_mask,
	output gmfw_pkg::ctrl_stat_t             stat
);

	localparam int HALF = (WINDOW - 1) / 2;
	localparam int WIN  = 2 * HALF + 1;

	logic [gmfw_pkg::CFG_W-1:0] width_q, height_q, weff, heff;
	logic [gmfw_pkg::Q_W-1:0]   q_q, lag_q;
	logic [gmfw_pkg::N_W-1:0]   n_q, total_q;
	logic [gmfw_pkg::ROW_W-1:0] row_q;
	logic [gmfw_pkg::COL_W-1:0] col_q, ocol_q;
	logic                       catch_q, cfg_pend_q;
	logic                       acc, real_px, past_end, reach;
	logic [gmfw_pkg::COL_W:0]   col_nxt, ocol_nxt;

	// Clamp the frame size: zero acts as one, width to what the line store holds, height to MAX_HEIGHT
	always_comb begin
		priority if (width_q == '0) begin
			weff = gmfw_pkg::CFG_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			weff = gmfw_pkg::CFG_W'(MAX_WIDTH);
		end else begin
			weff = width_q;
		end
		priority if (height_q == '0) begin
			heff = gmfw_pkg::CFG_W'(1);
		end else if (32'(height_q) > gmfw_pkg::MAX_HEIGHT) begin
			heff = gmfw_pkg::CFG_W'(gmfw_pkg::MAX_HEIGHT);
		end else begin
			heff = height_q;
		end
	end

	// Frame size products, registered from the clamped frame size
	always_ff @(posedge clk) begin
		total_q <= gmfw_pkg::N_W'(weff) * gmfw_pkg::N_W'(heff);
		lag_q   <= gmfw_pkg::Q_W'(HALF) * gmfw_pkg::Q_W'(weff) + gmfw_pkg::Q_W'(HALF);
	end

	// Step issue
	assign in_ready = s1_free && !cfg_pend_q && !catch_q;
	assign acc      = in_valid && in_ready;
	assign past_end = (row_q >= heff);
	assign real_px  = !in_data.flush && !past_end;
	assign reach    = (q_q >= lag_q);
	assign issue    = (acc && (real_px || past_end)) || (catch_q && s1_free);

	assign step.emit      = reach;
	assign step.frame_end = reach && ((n_q + gmfw_pkg::N_W'(1)) == total_q);
	assign step.pixel     = (acc && real_px) ? in_data.pixel_value : '0;
	assign step.col       = col_q;

	assign stat.catch_up = catch_q;
	assign stat.cfg_pend = cfg_pend_q;

	assign col_nxt  = {1'b0, col_q} + (gmfw_pkg::COL_W+1)'(1);
	assign ocol_nxt = {1'b0, ocol_q} + (gmfw_pkg::COL_W+1)'(1);

	// Row mask for the column entering now, column mask for the output centered now
	always_comb begin
		logic [gmfw_pkg::COL_W:0] oc_ext;
		oc_ext = {1'b0, ocol_q} + (gmfw_pkg::COL_W+1)'(HALF);
		for (int i = 0; i < WIN; i++) begin
			row_mask[i] = ({1'b0, row_q} >= (gmfw_pkg::ROW_W+1)'(i))
				&& ({1'b0, row_q} < ({1'b0, heff} + (gmfw_pkg::ROW_W+1)'(i)));
			col_mask[i] = (oc_ext >= (gmfw_pkg::COL_W+1)'(i))
				&& (oc_ext < ({1'b0, weff} + (gmfw_pkg::COL_W+1)'(i)));
		end
	end

	// Registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= gmfw_pkg::CFG_W'(gmfw_pkg::RST_WIDTH);
			height_q   <= gmfw_pkg::CFG_W'(gmfw_pkg::RST_HEIGHT);
			q_q        <= '0;
			n_q        <= '0;
			row_q      <= '0;
			col_q      <= '0;
			ocol_q     <= '0;
			catch_q    <= 1'b0;
			cfg_pend_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				gmfw_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
				gmfw_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			if (cfg_index == gmfw_pkg::REG_FRAME_WIDTH
					|| cfg_index == gmfw_pkg::REG_FRAME_HEIGHT) begin
				q_q     <= '0;
				n_q     <= '0;
				row_q   <= '0;
				col_q   <= '0;
				ocol_q  <= '0;
				catch_q <= 1'b0;
			end
			cfg_pend_q <= 1'b1;
		end else begin
			cfg_pend_q <= 1'b0;
			if (issue) begin
				if (step.frame_end) begin
					q_q     <= '0;
					n_q     <= '0;
					row_q   <= '0;
					col_q   <= '0;
					ocol_q  <= '0;
					catch_q <= 1'b0;
				end else begin
					q_q <= q_q + gmfw_pkg::Q_W'(1);
					if (col_nxt == {1'b0, weff}) begin
						col_q <= '0;
						row_q <= row_q + gmfw_pkg::ROW_W'(1);
					end else begin
						col_q <= col_nxt[gmfw_pkg::COL_W-1:0];
					end
					if (reach) begin
						n_q    <= n_q + gmfw_pkg::N_W'(1);
						ocol_q <= (ocol_nxt == {1'b0, weff}) ? '0
							: ocol_nxt[gmfw_pkg::COL_W-1:0];
					end
					// small frames: walk the position up to the first output
					catch_q <= !reach && (catch_q || past_end);
				end
			end
		end
	end

endmodule

@@ hw/rtl/gmfw_line_buf.sv @@
`timescale 1ns / 1ps

module gmfw_line_buf #(
	parameter int WINDOW    = gmfw_pkg::DEF_WINDOW,
	parameter int MAX_WIDTH = gmfw_pkg::DEF_MAX_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          issue,
	input  gmfw_pkg::step_t               step,
	input  logic [2*((WINDOW-1)/2):0]     row_mask,
	input  logic [2*((WINDOW-1)/2):0]     col_mask,
	output logic                          s1_free,
	input  logic                          s2_free,
	output logic                          vld_s1,
	output gmfw_pkg::step_t               step_s1,
	output logic [2*((WINDOW-1)/2):0]     cmask_s1,
	output logic [gmfw_pkg::PIX_W-1:0]    col_max
);

	localparam int HALF   = (WINDOW - 1) / 2;
	localparam int WIN    = 2 * HALF + 1;
	localparam int LINES  = (HALF > 0) ? 2 * HALF : 1;
	localparam int MEM_W  = LINES * gmfw_pkg::PIX_W;
	localparam int ADDR_W = $clog2(MAX_WIDTH);

	// One word per column: the pixels of the last rows at that column, newest in lane 0
	logic [MEM_W-1:0] mem [0:MAX_WIDTH-1];

	logic [MEM_W-1:0]   rd_s1, fwd_s1, old, wdata;
	logic               fwd_hit_s1, en1;
	logic [WIN-1:0]     rmask_s1;
	logic [ADDR_W-1:0]  raddr, waddr;

	assign raddr   = step.col[ADDR_W-1:0];
	assign waddr   = step_s1.col[ADDR_W-1:0];
	assign en1     = vld_s1 && s2_free;
	assign s1_free = !vld_s1 || s2_free;

	// Word written at the same edge as this read is taken from the forward path
	assign old = fwd_hit_s1 ? fwd_s1 : rd_s1;

	// Shift the column by one row
	always_comb begin
		wdata = old;
		wdata[gmfw_pkg::PIX_W-1:0] = step_s1.pixel;
		for (int j = 1; j < LINES; j++) begin
			wdata[j*gmfw_pkg::PIX_W +: gmfw_pkg::PIX_W] = old[(j-1)*gmfw_pkg::PIX_W +: gmfw_pkg::PIX_W];
		end
	end

	// Column maximum over the rows inside the frame
	always_comb begin
		logic [gmfw_pkg::PIX_W-1:0] best;
		best = rmask_s1[0] ? step_s1.pixel : '0;
		for (int i = 1; i < WIN; i++) begin
			if (rmask_s1[i]) begin
				best = gmfw_pkg::pix_max(best, old[(i-1)*gmfw_pkg::PIX_W +: gmfw_pkg::PIX_W]);
			end
		end
		col_max = best;
	end

	// Line store: read at issue, write back as the step leaves
	always_ff @(posedge clk) begin
		if (en1) begin
			mem[waddr] <= wdata;
		end
		if (issue) begin
			rd_s1 <= mem[raddr];
			fwd_s1 <= wdata;
			step_s1 <= step;
			rmask_s1 <= row_mask;
			cmask_s1 <= col_mask;
		end
	end

	// Stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			if (issue) begin
				vld_s1     <= 1'b1;
				fwd_hit_s1 <= en1 && (raddr == waddr);
			end else if (en1) begin
				vld_s1 <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/gmfw_win_max.sv @@
`timescale 1ns / 1ps

module gmfw_win_max #(
	parameter int WINDOW = gmfw_pkg::DEF_WINDOW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_s1,
	input  gmfw_pkg::step_t               step_s1,
	input  logic [2*((WINDOW-1)/2):0]     cmask_s1,
	input  logic [gmfw_pkg::PIX_W-1:0]    col_max,
	output logic                          s2_free,
	output logic                          out_valid,
	input  logic                          out_ready,
	output gmfw_pkg::pix_out_t            out_data
);

	localparam int HALF     = (WINDOW - 1) / 2;
	localparam int WIN      = 2 * HALF + 1;
	localparam int WIN_REGS = (WIN > 1) ? WIN - 1 : 1;

	logic                       vld_s2, emit_s2, fe_s2, en2, take;
	logic [gmfw_pkg::PIX_W-1:0] cmax_s2, best;
	logic [WIN-1:0]             cmask_s2;
	logic [gmfw_pkg::PIX_W-1:0] win_q [0:WIN_REGS-1];
	logic                       out_valid_q;
	gmfw_pkg::pix_out_t         out_q;

	assign en2     = vld_s2 && (!out_valid_q || out_ready);
	assign s2_free = !vld_s2 || en2;
	assign take    = vld_s1 && s2_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Window maximum: newest column plus the held ones, columns outside the frame dropped
	always_comb begin
		best = cmask_s2[0] ? cmax_s2 : '0;
		for (int k = 1; k < WIN; k++) begin
			if (cmask_s2[k]) begin
				best = gmfw_pkg::pix_max(best, win_q[k-1]);
			end
		end
	end

	// Stage 2 and column window
	always_ff @(posedge clk) begin
		if (take) begin
			cmax_s2  <= col_max;
			cmask_s2 <= cmask_s1;
			emit_s2  <= step_s1.emit;
			fe_s2    <= step_s1.frame_end;
		end
		if (en2) begin
			win_q[0] <= cmax_s2;
			for (int k = 1; k < WIN_REGS; k++) begin
				win_q[k] <= win_q[k-1];
			end
			if (emit_s2) begin
				out_q.max_value <= best;
				out_q.frame_end <= fe_s2;
			end
		end
	end

	// Stage 2 valid and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				vld_s2 <= 1'b1;
			end else if (en2) begin
				vld_s2 <= 1'b0;
			end
			if (en2 && emit_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/grayscale_max_filter_window.sv @@
`timescale 1ns / 1ps

// Square-window maximum filter (grayscale dilation) over a raster pixel stream.
// in channel: one pixel word per handshake in raster order; a word with flush set
//   carries no pixel and drains one pending output once the frame is complete.
// out channel: one word per output pixel, frame_end marks the last of the frame.
// cfg channel: index 0 = frame_width, index 1 = frame_height; cfg_ready is always
//   high. A width or height write restarts the frame; any write drops in_ready next cycle.
// Output n is produced by the word that carries pixel n + R*width + R, R = (WINDOW-1)/2.
// A result passes the line-store stage, stage 2 and the output register.
// Throughput: one word per cycle while in_ready is high. Each word takes a read-modify-write
//   of the line store (one word per column, 2R rows deep), a column max, then a window max.
// Frames smaller than R*width + R pixels: the first word past the last pixel, flush or
//   not, starts a catch-up that walks the stream position to the first output, in_ready low.
// A stalled receiver holds the output register; words already in the two pipeline
//   stages move up behind it, then in_ready drops.
// Reset: registers return to 640 x 480, in_ready starts low as after a register write.
//   The line store is not cleared; rows above the frame are masked out instead.
module grayscale_max_filter_window #(
	parameter int WINDOW    = gmfw_pkg::DEF_WINDOW,
	parameter int MAX_WIDTH = gmfw_pkg::DEF_MAX_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  gmfw_pkg::pix_in_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output gmfw_pkg::pix_out_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gmfw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gmfw_pkg::CFG_W-1:0]      cfg_data
);

	localparam int HALF = (WINDOW - 1) / 2;
	localparam int WIN  = 2 * HALF + 1;

	logic                       issue, s1_free, s2_free, vld_s1;
	gmfw_pkg::step_t            step, step_s1;
	logic [WIN-1:0]             row_mask, col_mask, cmask_s1;
	logic [gmfw_pkg::PIX_W-1:0] col_max;
	gmfw_pkg::ctrl_stat_t       stat;

	assign cfg_ready = 1'b1;

	gmfw_ctrl #(
		.WINDOW    (WINDOW),
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.s1_free   (s1_free),
		.issue     (issue),
		.step      (step),
		.row_mask  (row_mask),
		.col_mask  (col_mask),
		.stat      (stat)
	);

	gmfw_line_buf #(
		.WINDOW    (WINDOW),
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (issue),
		.step     (step),
		.row_mask (row_mask),
		.col_mask (col_mask),
		.s1_free  (s1_free),
		.s2_free  (s2_free),
		.vld_s1   (vld_s1),
		.step_s1  (step_s1),
		.cmask_s1 (cmask_s1),
		.col_max  (col_max)
	);

	gmfw_win_max #(
		.WINDOW (WINDOW)
	) u_win_max (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_s1    (vld_s1),
		.step_s1   (step_s1),
		.cmask_s1  (cmask_s1),
		.col_max   (col_max),
		.s2_free   (s2_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Derived frame size must settle before the next word
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("input taken right after a register write");

	// No word is taken while the position is walked up to the first output
	a_catch_up: assert property (@(posedge clk) disable iff (!arst_n)
		stat.catch_up |-> !(in_valid && in_ready))
		else $error("input taken during catch-up");

	// The frame ends only on a step that produces an output
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		issue && step.frame_end |-> step.emit)
		else $error("frame end on a step without output");

	// A step enters the line-store stage only when it is free
	a_issue_free: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> s1_free)
		else $error("step issued into an occupied stage");

endmodule

@@ test/grayscale_max_filter_window_test.sv @@
`timescale 1ns / 1ps

module grayscale_max_filter_window_test;

	localparam int WIN           = gmfw_pkg::DEF_WINDOW;
	localparam int R             = (WIN - 1) / 2;
	localparam int MAXW          = gmfw_pkg::DEF_MAX_WIDTH;
	localparam int HIST_DEPTH    = 2 * R * MAXW + 2 * R + 1;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_WORDS  = 80;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int unsigned WHOLE_FRAME = 32'hFFFF_FFFF;

	// Indexes with no register behind them
	localparam logic [gmfw_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [gmfw_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	gmfw_pkg::pix_in_t              in_data   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	gmfw_pkg::pix_out_t             out_data;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [gmfw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [gmfw_pkg::CFG_W-1:0]     cfg_data  = '0;

	grayscale_max_filter_window i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state: pixel history, geometry, stream position
	logic [gmfw_pkg::PIX_W-1:0] hist_mem [HIST_DEPTH];
	int                         cfg_width  = gmfw_pkg::RST_WIDTH;
	int                         cfg_height = gmfw_pkg::RST_HEIGHT;
	int                         row_pos    = 0;
	int                         col_pos    = 0;
	int                         out_pos    = 0;

	gmfw_pkg::pix_out_t dilated_q [$];	// expected output words, oldest first
	gmfw_pkg::pix_out_t want;
	int                 mismatch_count = 0;
	int unsigned        live_words     = 0;	// words that stored a pixel or drained one
	int unsigned        cycle_count    = 0;
	bit                 steady_mode    = 1'b0;	// no idling on either side

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d words still expected", $time, dilated_q.size());
			$display("grayscale_max_filter_window_test: done, errors");
			$finish;
		end
	end

	// Output checker and receiver stalls
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (dilated_q.size() == 0) begin
				$display("%0t: unexpected word, max_value %0d frame_end %0b", $time,
					out_data.max_value, out_data.frame_end);
				mismatch_count++;
			end else begin
				want = dilated_q.pop_front();
				if (out_data.max_value !== want.max_value) begin
					$display("%0t: max_value expected %0d, actual %0d", $time,
						want.max_value, out_data.max_value);
					mismatch_count++;
				end
				if (out_data.frame_end !== want.frame_end) begin
					$display("%0t: frame_end expected %0b, actual %0b", $time,
						want.frame_end, out_data.frame_end);
					mismatch_count++;
				end
			end
		end
		out_ready <= steady_mode || ($urandom_range(0, 99) >= 10);
	end

	// Effective geometry: zero acts as one, oversize clamps
	function automatic int act_width();
		if (cfg_width == 0) return 1;
		if (cfg_width > MAXW) return MAXW;
		return cfg_width;
	endfunction

	function automatic int act_height();
		if (cfg_height == 0) return 1;
		if (cfg_height > gmfw_pkg::MAX_HEIGHT) return gmfw_pkg::MAX_HEIGHT;
		return cfg_height;
	endfunction

	// Largest pixel in the window around output n; off-frame taps skipped
	function automatic logic [gmfw_pkg::PIX_W-1:0] window_peak(input int n, input int w,
			input int h);
		int                         orow, ocol, dr, dc, r, c;
		logic [gmfw_pkg::PIX_W-1:0] peak;
		orow = n / w;
		ocol = n % w;
		peak = '0;
		for (dr = -R; dr <= R; dr++) begin
			r = orow + dr;
			if (r < 0 || r >= h) continue;
			for (dc = -R; dc <= R; dc++) begin
				c = ocol + dc;
				if (c < 0 || c >= w) continue;
				if (hist_mem[(r * w + c) % HIST_DEPTH] > peak)
					peak = hist_mem[(r * w + c) % HIST_DEPTH];
			end
		end
		return peak;
	endfunction

	task automatic push_dilated(input int w, input int h);
		gmfw_pkg::pix_out_t res;
		res.max_value = window_peak(out_pos, w, h);
		out_pos++;
		res.frame_end = (out_pos >= w * h);
		if (res.frame_end) begin
			row_pos = 0;
			col_pos = 0;
			out_pos = 0;
		end
		dilated_q = {dilated_q, res};
	endtask

	// Advance the predictor by one accepted input word
	task automatic dilate_step(input gmfw_pkg::pix_in_t wd, output bit live);
		int w, h, total, lag, got;
		w     = act_width();
		h     = act_height();
		total = w * h;
		lag   = R * w + R;
		got   = row_pos * w + col_pos;
		live  = 1'b0;
		if (wd.flush || got >= total) begin
			// past the last pixel anything drains; before it a flush does nothing
			if (got >= total && out_pos < total) begin
				push_dilated(w, h);
				live = 1'b1;
			end
		end else begin
			hist_mem[got % HIST_DEPTH] = wd.pixel_value;
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
			live = 1'b1;
			if (got >= lag)
				push_dilated(w, h);
		end
	endtask

	// Send one input word, idling first at random
	task automatic send_word(input logic [gmfw_pkg::PIX_W-1:0] pix, input logic fl);
		gmfw_pkg::pix_in_t wd;
		bit                live;
		wd.pixel_value = pix;
		wd.flush       = fl;
		if (!steady_mode) begin
			while ($urandom_range(0, 99) < 10) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= wd;
		do @(posedge clk); while (!in_ready);
		dilate_step(wd, live);
		if (live)
			live_words++;
	endtask

	// Stop sending until every expected word has come back
	task automatic hold_for_results();
		in_valid <= 1'b0;
		while (dilated_q.size() != 0)
			@(posedge clk);
	endtask

	// Register write, only once the block has drained
	task automatic write_reg(input logic [gmfw_pkg::CFG_IDX_W-1:0] idx,
			input logic [gmfw_pkg::CFG_W-1:0] val);
		hold_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		// any real register write restarts the frame
		if (idx == gmfw_pkg::REG_FRAME_WIDTH)
			cfg_width = val;
		else if (idx == gmfw_pkg::REG_FRAME_HEIGHT)
			cfg_height = val;
		else
			return;
		row_pos = 0;
		col_pos = 0;
		out_pos = 0;
	endtask

	function automatic logic [gmfw_pkg::PIX_W-1:0] draw_pixel();
		unique case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return gmfw_pkg::PIX_W'($urandom);
		endcase
	endfunction

	// Up to cut pixels of a frame; a whole frame is drained to its end.
	// rough adds stray flushes, pixel words in the drain and result waits.
	task automatic feed_frame(input int unsigned cut, input bit rough);
		int unsigned total, k;
		total = act_width() * act_height();
		for (k = 0; k < total && k < cut; k++) begin
			if (rough && $urandom_range(0, 99) < 4)
				send_word(draw_pixel(), 1'b1);
			if (rough && $urandom_range(0, 999) < 5)
				hold_for_results();
			send_word(draw_pixel(), 1'b0);
		end
		if (cut < total)
			return;
		while (row_pos != 0 || col_pos != 0)
			send_word(draw_pixel(), rough ? ($urandom_range(0, 99) >= 15) : 1'b1);
	endtask

	// Reset geometry: first outputs of a default-width frame, paused midway, then cut
	task automatic test_reset_geometry();
		steady_mode = 1'b1;
		feed_frame(1286, 1'b0);
		hold_for_results();
		steady_mode = 1'b0;
		feed_frame(4, 1'b0);
	endtask

	// Single-pixel frame, stray flushes, pixel words in the drain, spare indexes
	task automatic test_corner_words();
		write_reg(gmfw_pkg::REG_FRAME_WIDTH, '0);
		write_reg(gmfw_pkg::REG_FRAME_HEIGHT, '0);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b1);
		send_word(8'hAA, 1'b1);	// nothing pending at frame start
		send_word(8'h00, 1'b0);
		send_word(8'h55, 1'b0);	// pixel after the last one drains
		write_reg(gmfw_pkg::REG_FRAME_WIDTH, 13'd6);
		write_reg(gmfw_pkg::REG_FRAME_HEIGHT, 13'd1);
		write_reg(REG_SPARE_A, '0);
		write_reg(REG_SPARE_B, '1);
		send_word(8'h01, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h33, 1'b1);	// flush before the last pixel
		send_word(8'h7F, 1'b0);
		send_word(8'hFE, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h10, 1'b0);
		while (row_pos != 0 || col_pos != 0)
			send_word(8'h00, 1'b1);
	endtask

	// Zero and oversize frame sizes: zero acts as one, oversize clamps
	task automatic test_extreme_sizes();
		write_reg(gmfw_pkg::REG_FRAME_WIDTH, '0);
		write_reg(gmfw_pkg::REG_FRAME_HEIGHT, 13'd5);
		feed_frame(WHOLE_FRAME, 1'b1);
		write_reg(gmfw_pkg::REG_FRAME_WIDTH, 13'd7);
		write_reg(gmfw_pkg::REG_FRAME_HEIGHT, '0);
		feed_frame(WHOLE_FRAME, 1'b1);
		write_reg(gmfw_pkg::REG_FRAME_WIDTH, 13'd1);
		write_reg(gmfw_pkg::REG_FRAME_HEIGHT, '1);
		feed_frame(24, 1'b1);
		write_reg(gmfw_pkg::REG_FRAME_WIDTH, '1);
		write_reg(gmfw_pkg::REG_FRAME_HEIGHT, 13'd2);
		feed_frame(16, 1'b0);
	endtask

	// Random small frames, back to back, some cut short by a register write
	task automatic test_random_frames();
		int unsigned goal, w, h, n, f, cut;
		goal = live_words + RANDOM_WORDS;
		while (live_words < goal) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 6);
			if ($urandom_range(0, 1)) begin
				write_reg(gmfw_pkg::REG_FRAME_WIDTH, gmfw_pkg::CFG_W'(w));
				write_reg(gmfw_pkg::REG_FRAME_HEIGHT, gmfw_pkg::CFG_W'(h));
			end else begin
				write_reg(gmfw_pkg::REG_FRAME_HEIGHT, gmfw_pkg::CFG_W'(h));
				write_reg(gmfw_pkg::REG_FRAME_WIDTH, gmfw_pkg::CFG_W'(w));
			end
			n = $urandom_range(1, 3);
			for (f = 0; f < n; f++) begin
				cut = ($urandom_range(0, 9) == 0) ?
					$urandom_range(0, act_width() * act_height()) : WHOLE_FRAME;
				feed_frame(cut, 1'b1);
				if (cut < act_width() * act_height())
					break;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_geometry();
		test_corner_words();
		test_extreme_sizes();
		test_random_frames();
		hold_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("grayscale_max_filter_window_test: done, clean");
		else
			$display("grayscale_max_filter_window_test: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/gmfw_pkg.sv
hw/rtl/gmfw_ctrl.sv
hw/rtl/gmfw_line_buf.sv
hw/rtl/gmfw_win_max.sv
hw/rtl/grayscale_max_filter_window.sv
test/grayscale_max_filter_window_test.sv
